@@ rtl/bbr_pkg.sv @@
// ----------------------------------------------------------------------------
// bbr_pkg: shared types and constants of the 3x3 RGBA box blur
// Word layouts, result tag, register indexes and the divide-by-nine constant.
// ----------------------------------------------------------------------------
package bbr_pkg;

    localparam int PIX_W      = 32;
    localparam int CH_W       = 8;
    localparam int CH_N       = 4;
    localparam int ROW_W      = 12;
    localparam int OUT_COL_W  = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 2;

    localparam int FRAME_WIDTH_RST  = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    // floor(s / 9) == (s * 3641) >> 15 for every s up to 9 * 255
    localparam int RECIP_W     = 12;
    localparam int RECIP_NINE  = 3641;
    localparam int RECIP_SHIFT = 15;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_start;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 was_filtered;
        logic                 last_of_run;
        logic                 frame_done;
    } out_word_t;

    // position and result flags of one pixel as it moves down the pipe
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 interior;
        logic                 border;
        logic                 last_px;
    } tag_t;

endpackage

@@ rtl/bbr_if.sv @@
// ----------------------------------------------------------------------------
// bbr_if: valid/ready channels of the box blur
// Pixel input channel and result output channel.
// ----------------------------------------------------------------------------
interface bbr_in_if;
    logic               valid;
    logic               ready;
    bbr_pkg::in_word_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bbr_out_if;
    logic               valid;
    logic               ready;
    bbr_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/box_blur_3x3_rgba.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_rgba: 3x3 box blur on a raster stream of RGBA pixels
// Line store, window, divide-by-nine and result queue.
// ----------------------------------------------------------------------------
// Use:
//   pixels  : one RGBA word per handshake in raster order; frame_start on a
//             word forces it to row 0, column 0.
//   results : words tagged with row and column. An interior word (averaged)
//             for (r-1, c-1) results from pixel (r, c), followed by
//             the input's own word if it lies on the frame border. An input
//             may give zero, one or two words.
//   wr_*    : frame_width / frame_height, written while the block is idle.
// Throughput: one pixel per clock while results average one word per pixel;
//   the line store is one RAM read and one write per pixel. Output drains one
//   word per clock while results.ready is high, so runs of two-word pixels
//   (last row, last column) hold back the input through pixels.ready.
// Pipeline: an accepted pixel passes the stage-1 register and the sum
//   register before its result words are written into the queue.
// Stall: results sit in an 8-word queue; ready drops when the queue plus
//   words still in the pipe could overflow it, so nothing is lost.
// Reset: sizes return to 640 x 480, position to row 0 / column 0, window
//   cleared. The line RAM is not cleared; entries are written before use.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgba #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    bbr_in_if.sink                         pixels,
    bbr_out_if.source                      results,
    input  logic                           wr_en,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [bbr_pkg::CFG_W-1:0]      wr_data
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int QW  = bbr_pkg::FIFO_PTR_W + 2;

    logic                                 take;
    logic [CW-1:0]                        rd_addr;
    logic                                 s1_valid;
    logic [CW-1:0]                        s1_addr;
    logic [bbr_pkg::PIX_W-1:0]            s1_px;
    bbr_pkg::tag_t                        s1_tag;
    logic [bbr_pkg::CNT_W-1:0]            s1_cnt;
    logic [8:0][bbr_pkg::PIX_W-1:0]       nbhd;
    logic [bbr_pkg::CNT_W-1:0]            s2_cnt;
    bbr_pkg::out_word_t                   wr_word0, wr_word1;
    logic [bbr_pkg::FIFO_PTR_W:0]         q_count;
    logic [QW-1:0]                        q_need;
    logic                                 pop;

    // words already in the queue, words in flight, and two for a new pixel
    assign q_need = QW'(q_count) + QW'(s1_cnt) + QW'(s2_cnt) + QW'(2);
    assign pixels.ready = (q_need <= QW'(bbr_pkg::FIFO_DEPTH));
    assign take = pixels.valid && pixels.ready;
    assign pop  = results.valid && results.ready;

    // stage 0/1: sizes, position, classification, RAM address
    bbr_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .take     (take),
        .in_word  (pixels.data),
        .rd_addr  (rd_addr),
        .s1_valid (s1_valid),
        .s1_addr  (s1_addr),
        .s1_px    (s1_px),
        .s1_tag   (s1_tag),
        .s1_cnt   (s1_cnt)
    );

    // stage 1: RAM data (or forwarded column) joins the window
    bbr_lstore #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lstore (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (take),
        .rd_addr  (rd_addr),
        .s1_valid (s1_valid),
        .s1_addr  (s1_addr),
        .s1_px    (s1_px),
        .nbhd     (nbhd)
    );

    // stage 2: divide sums by nine, build result words
    bbr_mean u_mean (
        .clk      (clk),
        .rst_n    (rst_n),
        .nbhd     (nbhd),
        .s1_px    (s1_px),
        .s1_tag   (s1_tag),
        .s1_cnt   (s1_cnt),
        .wr_cnt   (s2_cnt),
        .wr_word0 (wr_word0),
        .wr_word1 (wr_word1)
    );

    bbr_rfifo u_rfifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_cnt   (s2_cnt),
        .wr_word0 (wr_word0),
        .wr_word1 (wr_word1),
        .pop      (pop),
        .rd_valid (results.valid),
        .rd_word  (results.data),
        .count    (q_count)
    );

    // queue plus in-flight words never exceed the queue depth
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (QW'(q_count) + QW'(s1_cnt) + QW'(s2_cnt)) <= QW'(bbr_pkg::FIFO_DEPTH))
        else $error("result queue overcommitted");

    // an accepted pixel is in stage 1 on the next cycle
    a_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid)
        else $error("accepted pixel missing from stage 1");

    // stage 1 words reach the queue write in the following cycle
    a_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid |=> (s2_cnt == $past(s1_cnt)))
        else $error("stage 2 word count mismatch");

    // an empty pipe and queue never hold off the source
    a_no_deadlock: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == '0 && s1_cnt == '0 && s2_cnt == '0) |-> pixels.ready)
        else $error("input stalled with nothing pending");

endmodule

@@ rtl/bbr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbr_ctrl: size registers, raster position and first pipe stage
// Resolves row/column of each accepted word and classifies it.
// ----------------------------------------------------------------------------
module bbr_ctrl #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bbr_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [bbr_pkg::CFG_W-1:0]          wr_data,
    input  logic                               take,
    input  bbr_pkg::in_word_t                  in_word,
    output logic [$clog2(MAX_WIDTH)-1:0]       rd_addr,
    output logic                               s1_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]       s1_addr,
    output logic [bbr_pkg::PIX_W-1:0]          s1_px,
    output bbr_pkg::tag_t                      s1_tag,
    output logic [bbr_pkg::CNT_W-1:0]          s1_cnt
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (AW > bbr_pkg::CFG_W) ? AW : bbr_pkg::CFG_W;
    localparam int RW = bbr_pkg::ROW_W;

    logic [bbr_pkg::CFG_W-1:0] width_reg;
    logic [bbr_pkg::CFG_W-1:0] height_reg;
    logic [CW-1:0]             col_reg, col_next;
    logic [RW-1:0]             row_reg, row_next;

    logic                      s1_valid_reg;
    logic [CW-1:0]             s1_addr_reg;
    logic [bbr_pkg::PIX_W-1:0] s1_px_reg;
    bbr_pkg::tag_t             s1_tag_reg, tag_next;
    logic [bbr_pkg::CNT_W-1:0] s1_cnt_reg, cnt_next;

    logic [EW-1:0] w_raw, w_eff;
    logic [RW-1:0] h_eff;
    logic [CW-1:0] col_start, cur_col;
    logic [RW-1:0] row_start, row_wrap, cur_row;
    logic          col_last, row_last, interior, border;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbr_pkg::CFG_W'(bbr_pkg::FRAME_WIDTH_RST);
            height_reg <= bbr_pkg::CFG_W'(bbr_pkg::FRAME_HEIGHT_RST);
        end
        else if (wr_en)
        begin
            case (wr_index)
                bbr_pkg::REG_FRAME_WIDTH:  width_reg  <= wr_data;
                bbr_pkg::REG_FRAME_HEIGHT: height_reg <= wr_data;
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, width clamps to the store depth
    always_comb
    begin
        w_raw = EW'(width_reg);
        if (w_raw == '0)
            w_eff = EW'(1);
        else if (w_raw > EW'(MAX_WIDTH))
            w_eff = EW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        h_eff = (height_reg == '0) ? RW'(1) : RW'(height_reg);
    end

    // position of the word being accepted, with wrap for shrunk sizes
    always_comb
    begin
        col_start = in_word.frame_start ? '0 : col_reg;
        row_start = in_word.frame_start ? '0 : row_reg;
        if (EW'(col_start) >= w_eff)
        begin
            cur_col  = '0;
            row_wrap = row_start + RW'(1);
        end
        else
        begin
            cur_col  = col_start;
            row_wrap = row_start;
        end
        cur_row  = (row_wrap >= h_eff) ? '0 : row_wrap;
        col_last = (EW'(cur_col) == w_eff - EW'(1));
        row_last = (cur_row == h_eff - RW'(1));
        interior = (cur_row >= RW'(2)) && (cur_col >= CW'(2));
        border   = (cur_row == '0) || row_last || (cur_col == '0) || col_last;

        tag_next.row      = cur_row;
        tag_next.col      = bbr_pkg::OUT_COL_W'(cur_col);
        tag_next.interior = interior;
        tag_next.border   = border;
        tag_next.last_px  = row_last && col_last;
        cnt_next          = bbr_pkg::CNT_W'(interior) + bbr_pkg::CNT_W'(border);

        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : cur_row + RW'(1);
        end
        else
        begin
            col_next = cur_col + CW'(1);
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_cnt_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            s1_cnt_reg   <= take ? cnt_next : '0;
            if (take)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_addr_reg <= cur_col;
            s1_px_reg   <= in_word.pixel_in;
            s1_tag_reg  <= tag_next;
        end
    end

    assign rd_addr  = cur_col;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_px    = s1_px_reg;
    assign s1_tag   = s1_tag_reg;
    assign s1_cnt   = s1_cnt_reg;

endmodule

@@ rtl/bbr_lstore.sv @@
// ----------------------------------------------------------------------------
// bbr_lstore: line store and 3x3 window
// One RAM holds the two rows above per column; the window keeps two columns.
// ----------------------------------------------------------------------------
module bbr_lstore #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
    input  logic                                  s1_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]          s1_addr,
    input  logic [bbr_pkg::PIX_W-1:0]             s1_px,
    output logic [8:0][bbr_pkg::PIX_W-1:0]        nbhd
);

    localparam int PW = bbr_pkg::PIX_W;

    // entry = {two rows above, one row above}
    logic [2*PW-1:0]      line_mem [MAX_WIDTH];
    logic [2*PW-1:0]      rdata_reg;
    logic                 fwd_reg;
    logic [5:0][PW-1:0]   win_reg;
    logic [PW-1:0]        top, mid;

    // read-first RAM; write back the shifted column as it leaves stage 1
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= line_mem[rd_addr];
        if (s1_valid)
            line_mem[s1_addr] <= {mid, s1_px};
    end

    // same column read while written: data comes from the window instead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_reg <= 1'b0;
        else
            fwd_reg <= rd_en && s1_valid && (rd_addr == s1_addr);
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            top = win_reg[4];
            mid = win_reg[5];
        end
        else
        begin
            top = rdata_reg[2*PW-1:PW];
            mid = rdata_reg[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= '0;
        else if (s1_valid)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top;
            win_reg[4] <= mid;
            win_reg[5] <= s1_px;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            nbhd[k] = win_reg[k];
        nbhd[6] = top;
        nbhd[7] = mid;
        nbhd[8] = s1_px;
    end

endmodule

@@ rtl/bbr_mean.sv @@
// ----------------------------------------------------------------------------
// bbr_mean: channel sums and divide by nine
// Registers the four 9-term sums, then forms the interior and border words.
// ----------------------------------------------------------------------------
module bbr_mean (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [8:0][bbr_pkg::PIX_W-1:0]        nbhd,
    input  logic [bbr_pkg::PIX_W-1:0]             s1_px,
    input  bbr_pkg::tag_t                         s1_tag,
    input  logic [bbr_pkg::CNT_W-1:0]             s1_cnt,
    output logic [bbr_pkg::CNT_W-1:0]             wr_cnt,
    output bbr_pkg::out_word_t                    wr_word0,
    output bbr_pkg::out_word_t                    wr_word1
);

    localparam int SW = bbr_pkg::SUM_W;
    localparam int CW = bbr_pkg::CH_W;
    localparam int MW = bbr_pkg::SUM_W + bbr_pkg::RECIP_W;

    logic [bbr_pkg::CH_N-1:0][SW-1:0] sum_next, sum_reg;
    logic [bbr_pkg::PIX_W-1:0]        px_reg;
    bbr_pkg::tag_t                    tag_reg;
    logic [bbr_pkg::CNT_W-1:0]        cnt_reg;
    logic [bbr_pkg::PIX_W-1:0]        avg;
    logic [MW-1:0]                    prod;
    bbr_pkg::out_word_t               int_word, brd_word;

    always_comb
    begin
        for (int ch = 0; ch < bbr_pkg::CH_N; ch++)
        begin
            sum_next[ch] = SW'(nbhd[0][CW*ch +: CW]) + SW'(nbhd[1][CW*ch +: CW])
                         + SW'(nbhd[2][CW*ch +: CW]) + SW'(nbhd[3][CW*ch +: CW])
                         + SW'(nbhd[4][CW*ch +: CW]) + SW'(nbhd[5][CW*ch +: CW])
                         + SW'(nbhd[6][CW*ch +: CW]) + SW'(nbhd[7][CW*ch +: CW])
                         + SW'(nbhd[8][CW*ch +: CW]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= s1_cnt;
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        px_reg  <= s1_px;
        tag_reg <= s1_tag;
    end

    // floor division by nine as a reciprocal multiply
    always_comb
    begin
        prod = '0;
        for (int ch = 0; ch < bbr_pkg::CH_N; ch++)
        begin
            prod = MW'(sum_reg[ch]) * MW'(bbr_pkg::RECIP_NINE);
            avg[CW*ch +: CW] = prod[bbr_pkg::RECIP_SHIFT +: CW];
        end
    end

    always_comb
    begin
        int_word.pixel_out    = avg;
        int_word.out_row      = tag_reg.row - bbr_pkg::ROW_W'(1);
        int_word.out_col      = tag_reg.col - bbr_pkg::OUT_COL_W'(1);
        int_word.was_filtered = 1'b1;
        int_word.last_of_run  = !tag_reg.border;
        int_word.frame_done   = tag_reg.last_px;

        brd_word.pixel_out    = px_reg;
        brd_word.out_row      = tag_reg.row;
        brd_word.out_col      = tag_reg.col;
        brd_word.was_filtered = 1'b0;
        brd_word.last_of_run  = 1'b1;
        brd_word.frame_done   = tag_reg.last_px;
    end

    assign wr_cnt   = cnt_reg;
    assign wr_word0 = tag_reg.interior ? int_word : brd_word;
    assign wr_word1 = brd_word;

endmodule

@@ rtl/bbr_rfifo.sv @@
// ----------------------------------------------------------------------------
// bbr_rfifo: result queue
// Takes up to two words per cycle, hands out one; doubles as output register.
// ----------------------------------------------------------------------------
module bbr_rfifo (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [bbr_pkg::CNT_W-1:0]             wr_cnt,
    input  bbr_pkg::out_word_t                    wr_word0,
    input  bbr_pkg::out_word_t                    wr_word1,
    input  logic                                  pop,
    output logic                                  rd_valid,
    output bbr_pkg::out_word_t                    rd_word,
    output logic [bbr_pkg::FIFO_PTR_W:0]          count
);

    localparam int PW = bbr_pkg::FIFO_PTR_W;

    bbr_pkg::out_word_t slot_reg [bbr_pkg::FIFO_DEPTH];
    logic [PW-1:0]      wptr_reg, rptr_reg;
    logic [PW:0]        count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_cnt != '0)
            slot_reg[wptr_reg] <= wr_word0;
        if (wr_cnt == bbr_pkg::CNT_W'(2))
            slot_reg[wptr_reg + PW'(1)] <= wr_word1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + PW'(wr_cnt);
            rptr_reg  <= rptr_reg + PW'(pop);
            count_reg <= count_reg + (PW+1)'(wr_cnt) - (PW+1)'(pop);
        end
    end

    assign rd_valid = (count_reg != '0);
    assign rd_word  = slot_reg[rptr_reg];
    assign count    = count_reg;

endmodule
